// ===== rtl/core/odo_pkg.sv =====
// ----------------------------------------------------------------------------
// odo_pkg
// Shared widths, constants and the arctangent table for the odometry core.
// ----------------------------------------------------------------------------
package odo_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_N = 24;

	// serial multiplier: multiplicand, multiplier, product
	localparam int MUL_AW = 54;
	localparam int MUL_BW = 46;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	// serial divider: dividend, divisor
	localparam int DIV_NW = 76;
	localparam int DIV_DW = 68;

	// CORDIC datapath, Q1.30 with headroom
	localparam int COR_W = 34;

	localparam logic [MUL_BW-1:0] TURN_K = 46'd44798133900177;
	localparam logic [MUL_BW-1:0] MICRO = 46'd1000000;
	localparam logic signed [COR_W-1:0] CORDIC_GAIN = 34'sd652032874;

	// atan(2^-i) as a binary angle, full turn = 2^32
	function automatic logic [29:0] atan_bam(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0: v = 30'd536870912;
			5'd1: v = 30'd316933406;
			5'd2: v = 30'd167458907;
			5'd3: v = 30'd85004756;
			5'd4: v = 30'd42667331;
			5'd5: v = 30'd21354465;
			5'd6: v = 30'd10679838;
			5'd7: v = 30'd5340245;
			5'd8: v = 30'd2670163;
			5'd9: v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/core/odo_in_if.sv =====
// ----------------------------------------------------------------------------
// odo_in_if
// Input channel: timestamped wheel angle pair.
// ----------------------------------------------------------------------------
interface odo_in_if import odo_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [31:0] left_angle;
	logic signed [31:0] right_angle;
	logic [47:0] time_us;
	logic positions_valid;

	modport source(output valid, left_angle, right_angle, time_us, positions_valid,
		input ready);
	modport sink(input valid, left_angle, right_angle, time_us, positions_valid,
		output ready);
endinterface

// ===== rtl/core/odo_out_if.sv =====
// ----------------------------------------------------------------------------
// odo_out_if
// Output channel: pose, heading quaternion and body speeds.
// ----------------------------------------------------------------------------
interface odo_out_if import odo_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic [31:0] heading;
	logic signed [15:0] quat_z;
	logic signed [15:0] quat_w;
	logic signed [31:0] linear_speed;
	logic signed [31:0] angular_speed;

	modport source(output valid, pos_x, pos_y, heading, quat_z, quat_w, linear_speed,
		angular_speed, input ready);
	modport sink(input valid, pos_x, pos_y, heading, quat_z, quat_w, linear_speed,
		angular_speed, output ready);
endinterface

// ===== rtl/core/odo_mul.sv =====
// ----------------------------------------------------------------------------
// odo_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module odo_mul import odo_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [MUL_AW-1:0] a,
	input  logic [MUL_BW-1:0] b,
	output logic              done,
	output logic [MUL_PW-1:0] p
);
	logic busy_q, done_q;
	logic [MUL_PW-1:0] a_q, p_q;
	logic [MUL_BW-1:0] b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && b_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// stops as soon as the remaining multiplier bits are zero
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= MUL_PW'(a);
			b_q <= b;
			p_q <= '0;
		end else if (busy_q && b_q != '0) begin
			if (b_q[0]) begin
				p_q <= p_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign p = p_q;
endmodule

// ===== rtl/core/odo_div.sv =====
// ----------------------------------------------------------------------------
// odo_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module odo_div import odo_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] n,
	input  logic [DIV_DW-1:0] d,
	output logic              done,
	output logic [DIV_NW-1:0] q
);
	localparam int CW = $clog2(DIV_NW + 1);

	logic busy_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [DIV_NW-1:0] n_q, q_q;
	logic [DIV_DW-1:0] d_q, rem_q;
	logic [DIV_DW:0] trial, diff;
	logic ge;

	assign trial = {rem_q, n_q[DIV_NW-1]};
	assign ge = trial >= {1'b0, d_q};
	assign diff = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(DIV_NW)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= n;
			d_q <= d;
			rem_q <= '0;
			q_q <= '0;
		end else if (busy_q && cnt_q != CW'(DIV_NW)) begin
			rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
			n_q <= n_q << 1;
			q_q <= {q_q[DIV_NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign q = q_q;
endmodule

// ===== rtl/core/odo_cordic.sv =====
// ----------------------------------------------------------------------------
// odo_cordic
// Rotation-mode CORDIC, one micro-rotation per cycle, angle folded to the
// right half plane.
// ----------------------------------------------------------------------------
module odo_cordic import odo_pkg::*; #(
	parameter int STEPS = CORDIC_STEPS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [31:0]             angle,
	output logic                    done,
	output logic signed [COR_W-1:0] cos_out,
	output logic signed [COR_W-1:0] sin_out
);
	localparam int CW = $clog2(STEPS + 1);

	logic busy_q, done_q, fold_q;
	logic [CW-1:0] cnt_q;
	logic signed [COR_W-1:0] x_q, y_q, z_q, c_q, s_q;
	logic signed [COR_W-1:0] xs, ys, at;
	logic fold;

	assign fold = angle[31] ^ angle[30];
	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;
	assign at = $signed({{(COR_W - 30){1'b0}}, atan_bam(5'(cnt_q))});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(STEPS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			fold_q <= fold;
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			// folding subtracts half a turn: flip the top bit
			z_q <= COR_W'($signed({angle[31] ^ fold, angle[30:0]}));
		end else if (busy_q) begin
			if (cnt_q == CW'(STEPS)) begin
				c_q <= fold_q ? -x_q : x_q;
				s_q <= fold_q ? -y_q : y_q;
			end else if (!z_q[COR_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign done = done_q;
	assign cos_out = c_q;
	assign sin_out = s_q;
endmodule

// ===== rtl/core/diff_drive_odometry.sv =====
// ----------------------------------------------------------------------------
// diff_drive_odometry
// Differential-drive wheel odometry: pose, heading quaternion and speeds.
// ----------------------------------------------------------------------------
// Works on one item at a time. An item that is dropped, latches the first
// sample or has a non-increasing timestamp is handled in the idle state. An
// integrating item runs a sequence on one shift-add multiplier, one restoring
// divider (four divides, one when the wheel separation is zero) and one CORDIC
// (used twice); with a zero wheel separation the heading and angular-speed
// steps are skipped. The result waits in an output register, so the next item
// is taken while it is still pending.
module diff_drive_odometry import odo_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	odo_in_if.sink      samples,
	odo_out_if.source   pose,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MSUM  = 4'd1;
	localparam logic [3:0] ST_MDIFF = 4'd2;
	localparam logic [3:0] ST_LMUL  = 4'd3;
	localparam logic [3:0] ST_LDIV  = 4'd4;
	localparam logic [3:0] ST_TMUL  = 4'd5;
	localparam logic [3:0] ST_TDIV  = 4'd6;
	localparam logic [3:0] ST_AMUL  = 4'd7;
	localparam logic [3:0] ST_ADIV1 = 4'd8;
	localparam logic [3:0] ST_ADIV2 = 4'd9;
	localparam logic [3:0] ST_COR1  = 4'd10;
	localparam logic [3:0] ST_XMUL  = 4'd11;
	localparam logic [3:0] ST_YMUL  = 4'd12;
	localparam logic [3:0] ST_COR2  = 4'd13;
	localparam logic [3:0] ST_OUT   = 4'd14;

	localparam logic REG_RADIUS = 1'b0;
	localparam logic REG_SEP = 1'b1;

	logic [19:0] radius_q, sep_q;
	logic [3:0] state_q;
	logic launch_q;

	logic signed [31:0] prev_left_q, prev_right_q;
	logic [47:0] prev_time_q, dt_q;
	logic have_prev_q;
	logic [31:0] acc_x_q, acc_y_q, acc_head_q;

	logic signed [33:0] dsum_q, ddiff_q;
	logic [53:0] mag_sum_q, mag_diff_q;
	logic neg_sum_q, neg_diff_q;
	logic signed [37:0] ds_q;
	logic [DIV_NW-1:0] tmp_q;
	logic [31:0] lin_q, ang_q;
	logic signed [COR_W-1:0] cos_q, sin_q;

	logic out_valid_q;
	logic [31:0] out_x_q, out_y_q, out_head_q, out_lin_q, out_ang_q;
	logic [15:0] out_qz_q, out_qw_q;

	// multiplier, divider and CORDIC hookup
	logic mul_start, mul_done, div_start, div_done, cor_start, cor_done;
	logic [MUL_AW-1:0] mul_a;
	logic [MUL_BW-1:0] mul_b;
	logic [MUL_PW-1:0] mul_p;
	logic [DIV_NW-1:0] div_n, div_q;
	logic [DIV_DW-1:0] div_d;
	logic [31:0] cor_angle;
	logic signed [COR_W-1:0] cor_c, cor_s;

	logic in_acc;
	logic signed [32:0] dl, dr;
	logic [33:0] abs_sum, abs_diff;
	logic [37:0] abs_ds;
	logic [COR_W-1:0] abs_cos, abs_sin;
	logic signed [54:0] sum_p, sum_r;
	logic signed [37:0] ds_next;
	logic [63:0] term_raw, term_sgn, term_rnd;
	logic term_neg;
	logic [31:0] dbam;

	function automatic logic [31:0] sat32(input logic neg, input logic [DIV_NW-1:0] m);
		logic [31:0] r;
		if (!neg) begin
			r = (m > DIV_NW'(64'd2147483647)) ? 32'h7fff_ffff : m[31:0];
		end else begin
			r = (m > DIV_NW'(64'd2147483648)) ? 32'h8000_0000 : (~m[31:0] + 32'd1);
		end
		return r;
	endfunction

	function automatic logic [15:0] to_q15(input logic signed [COR_W-1:0] v);
		logic signed [COR_W:0] t;
		logic signed [COR_W-15:0] r;
		logic [15:0] o;
		t = (COR_W + 1)'(v) + (COR_W + 1)'(16384);
		r = (COR_W - 14)'(t >>> 15);
		if (r > (COR_W - 14)'(32767)) begin
			o = 16'h7fff;
		end else if (r < -(COR_W - 14)'(32768)) begin
			o = 16'h8000;
		end else begin
			o = r[15:0];
		end
		return o;
	endfunction

	// ---- configuration port ----
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SEP) ? {12'd0, sep_q} : {12'd0, radius_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 20'd2163;
			sep_q <= 20'd11141;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_RADIUS) begin
				radius_q <= pwdata[19:0];
			end else begin
				sep_q <= pwdata[19:0];
			end
		end
	end

	// ---- datapath helpers ----
	assign samples.ready = (state_q == ST_IDLE);
	assign in_acc = samples.valid && samples.ready;

	assign dl = 33'(samples.left_angle) - 33'(prev_left_q);
	assign dr = 33'(samples.right_angle) - 33'(prev_right_q);

	assign abs_sum = dsum_q[33] ? 34'(-dsum_q) : 34'(dsum_q);
	assign abs_diff = ddiff_q[33] ? 34'(-ddiff_q) : 34'(ddiff_q);
	assign abs_ds = ds_q[37] ? 38'(-ds_q) : 38'(ds_q);
	assign abs_cos = cos_q[COR_W-1] ? COR_W'(-cos_q) : COR_W'(cos_q);
	assign abs_sin = sin_q[COR_W-1] ? COR_W'(-sin_q) : COR_W'(sin_q);

	// ds = round(r * (dR + dL) / 2^17)
	assign sum_p = dsum_q[33] ? -$signed(mul_p[54:0]) : $signed(mul_p[54:0]);
	assign sum_r = sum_p + 55'sd65536;
	assign ds_next = 38'(sum_r >>> 17);

	// position step: (ds * trig + 2^29) >> 30
	assign term_neg = ds_q[37] ^ ((state_q == ST_XMUL) ? cos_q[COR_W-1] : sin_q[COR_W-1]);
	assign term_raw = mul_p[63:0];
	assign term_sgn = term_neg ? (~term_raw + 64'd1) : term_raw;
	assign term_rnd = term_sgn + 64'd536870912;

	assign dbam = neg_diff_q ? (~div_q[31:0] + 32'd1) : div_q[31:0];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		div_n = tmp_q;
		div_d = DIV_DW'(dt_q);
		cor_angle = acc_head_q;
		case (state_q)
			ST_MSUM: begin
				mul_a = MUL_AW'(abs_sum);
				mul_b = MUL_BW'(radius_q);
			end
			ST_MDIFF: begin
				mul_a = MUL_AW'(abs_diff);
				mul_b = MUL_BW'(radius_q);
			end
			ST_LMUL: begin
				mul_a = mag_sum_q;
				mul_b = MICRO;
			end
			ST_TMUL: begin
				mul_a = mag_diff_q;
				mul_b = TURN_K;
			end
			ST_TDIV, ST_ADIV2: begin
				div_d = DIV_DW'(sep_q);
			end
			ST_AMUL: begin
				mul_a = mag_diff_q;
				mul_b = MICRO;
			end
			ST_XMUL: begin
				mul_a = MUL_AW'(abs_ds);
				mul_b = MUL_BW'(abs_cos);
			end
			ST_YMUL: begin
				mul_a = MUL_AW'(abs_ds);
				mul_b = MUL_BW'(abs_sin);
			end
			ST_COR2: begin
				cor_angle = {1'b0, acc_head_q[31:1]};
			end
			default: begin
			end
		endcase
	end

	assign mul_start = !launch_q && (state_q inside {ST_MSUM, ST_MDIFF, ST_LMUL, ST_TMUL,
		ST_AMUL, ST_XMUL, ST_YMUL});
	assign div_start = !launch_q && (state_q inside {ST_LDIV, ST_TDIV, ST_ADIV1, ST_ADIV2});
	assign cor_start = !launch_q && (state_q inside {ST_COR1, ST_COR2});

	odo_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .p(mul_p)
	);

	odo_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .n(div_n), .d(div_d),
		.done(div_done), .q(div_q)
	);

	odo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_start), .angle(cor_angle),
		.done(cor_done), .cos_out(cor_c), .sin_out(cor_s)
	);

	// ---- sequencer and state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			launch_q <= 1'b0;
			have_prev_q <= 1'b0;
			prev_left_q <= '0;
			prev_right_q <= '0;
			prev_time_q <= '0;
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_head_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (mul_start || div_start || cor_start) begin
				launch_q <= 1'b1;
			end
			if (pose.valid && pose.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && samples.positions_valid) begin
						if (!have_prev_q) begin
							have_prev_q <= 1'b1;
							prev_left_q <= samples.left_angle;
							prev_right_q <= samples.right_angle;
							prev_time_q <= samples.time_us;
						end else if (samples.time_us > prev_time_q) begin
							prev_left_q <= samples.left_angle;
							prev_right_q <= samples.right_angle;
							prev_time_q <= samples.time_us;
							state_q <= ST_MSUM;
						end
					end
				end
				ST_MSUM: begin
					if (mul_done) begin
						launch_q <= 1'b0;
						state_q <= ST_MDIFF;
					end
				end
				ST_MDIFF: begin
					if (mul_done) begin
						launch_q <= 1'b0;
						state_q <= ST_LMUL;
					end
				end
				ST_LMUL: begin
					if (mul_done) begin
						launch_q <= 1'b0;
						state_q <= ST_LDIV;
					end
				end
				ST_LDIV: begin
					if (div_done) begin
						launch_q <= 1'b0;
						state_q <= (sep_q == '0) ? ST_COR1 : ST_TMUL;
					end
				end
				ST_TMUL: begin
					if (mul_done) begin
						launch_q <= 1'b0;
						state_q <= ST_TDIV;
					end
				end
				ST_TDIV: begin
					if (div_done) begin
						launch_q <= 1'b0;
						acc_head_q <= acc_head_q + dbam;
						state_q <= ST_AMUL;
					end
				end
				ST_AMUL: begin
					if (mul_done) begin
						launch_q <= 1'b0;
						state_q <= ST_ADIV1;
					end
				end
				ST_ADIV1: begin
					if (div_done) begin
						launch_q <= 1'b0;
						state_q <= ST_ADIV2;
					end
				end
				ST_ADIV2: begin
					if (div_done) begin
						launch_q <= 1'b0;
						state_q <= ST_COR1;
					end
				end
				ST_COR1: begin
					if (cor_done) begin
						launch_q <= 1'b0;
						state_q <= ST_XMUL;
					end
				end
				ST_XMUL: begin
					if (mul_done) begin
						launch_q <= 1'b0;
						acc_x_q <= acc_x_q + term_rnd[61:30];
						state_q <= ST_YMUL;
					end
				end
				ST_YMUL: begin
					if (mul_done) begin
						launch_q <= 1'b0;
						acc_y_q <= acc_y_q + term_rnd[61:30];
						state_q <= ST_COR2;
					end
				end
				ST_COR2: begin
					if (cor_done) begin
						launch_q <= 1'b0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || pose.ready) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				dsum_q <= 34'(dr) + 34'(dl);
				ddiff_q <= 34'(dr) - 34'(dl);
				dt_q <= samples.time_us - prev_time_q;
				ang_q <= '0;
			end
			ST_MSUM: begin
				if (mul_done) begin
					mag_sum_q <= mul_p[53:0];
					neg_sum_q <= dsum_q[33];
					ds_q <= ds_next;
				end
			end
			ST_MDIFF: begin
				if (mul_done) begin
					mag_diff_q <= mul_p[53:0];
					neg_diff_q <= ddiff_q[33];
				end
			end
			ST_LMUL, ST_AMUL: begin
				if (mul_done) begin
					tmp_q <= mul_p[DIV_NW-1:0];
				end
			end
			ST_LDIV: begin
				if (div_done) begin
					lin_q <= sat32(neg_sum_q, div_q >> 17);
				end
			end
			ST_TMUL: begin
				if (mul_done) begin
					tmp_q <= DIV_NW'(mul_p[MUL_PW-1:32]);
				end
			end
			ST_ADIV1: begin
				if (div_done) begin
					tmp_q <= div_q;
				end
			end
			ST_ADIV2: begin
				if (div_done) begin
					ang_q <= sat32(neg_diff_q, div_q);
				end
			end
			ST_COR1, ST_COR2: begin
				if (cor_done) begin
					cos_q <= cor_c;
					sin_q <= cor_s;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || pose.ready) begin
					out_x_q <= acc_x_q;
					out_y_q <= acc_y_q;
					out_head_q <= acc_head_q;
					out_qz_q <= to_q15(sin_q);
					out_qw_q <= to_q15(cos_q);
					out_lin_q <= lin_q;
					out_ang_q <= ang_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign pose.valid = out_valid_q;
	assign pose.pos_x = out_x_q;
	assign pose.pos_y = out_y_q;
	assign pose.heading = out_head_q;
	assign pose.quat_z = out_qz_q;
	assign pose.quat_w = out_qw_q;
	assign pose.linear_speed = out_lin_q;
	assign pose.angular_speed = out_ang_q;
endmodule
